[src/running_stats_top_two_min_max_defines.svh]
// Assertion macros shared by the running statistics RTL.
// Included by the top level; depends on nothing.
`ifndef RUNNING_STATS_TOP_TWO_MIN_MAX_DEFINES_SVH
`define RUNNING_STATS_TOP_TWO_MIN_MAX_DEFINES_SVH

// same-cycle implication
`define RSTAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSTAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rstat_pkg.sv]
// Shared types and constants for the running statistics block.
// No dependencies.
package rstat_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int SUM_WIDTH   = 48;
   localparam int SQ_WIDTH    = 63;

   localparam logic FUNC_APPLY = 1'b0;
   localparam logic FUNC_INVAL = 1'b1;

   typedef enum logic [1:0] {
      OP_INVAL,
      OP_SOLE,
      OP_ADD,
      OP_UPDATE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   two;
   } step_ctl_type;

endpackage

[src/rstat_square_stage.sv]
// Input register of the running statistics block; squares both values on entry.
// Depends on nothing but its parameters.
module rstat_square_stage #(
   parameter int VALUE_WIDTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_func,
   input  logic                          in_is_update,
   input  logic [ID_WIDTH-1:0]           in_item_id,
   input  logic signed [VALUE_WIDTH-1:0] in_new_value,
   input  logic signed [VALUE_WIDTH-1:0] in_prior_value,
   input  logic                          take,
   output logic                          valid,
   output logic                          func,
   output logic                          is_update,
   output logic [ID_WIDTH-1:0]           item_id,
   output logic signed [VALUE_WIDTH-1:0] new_value,
   output logic signed [VALUE_WIDTH-1:0] prior_value,
   output logic [2*VALUE_WIDTH-1:0]      sq_new,
   output logic [2*VALUE_WIDTH-1:0]      sq_prior
);

   logic                          valid_ff, valid_in;
   logic                          func_ff, is_update_ff;
   logic [ID_WIDTH-1:0]           item_id_ff;
   logic signed [VALUE_WIDTH-1:0] new_value_ff, prior_value_ff;
   logic [2*VALUE_WIDTH-1:0]      sq_new_ff, sq_prior_ff;
   logic signed [2*VALUE_WIDTH-1:0] sq_new_in, sq_prior_in;
   logic                          load;

   assign in_ready    = !valid_ff || take;
   assign load        = in_valid && in_ready;
   assign sq_new_in   = in_new_value * in_new_value;
   assign sq_prior_in = in_prior_value * in_prior_value;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff        <= in_func;
         is_update_ff   <= in_is_update;
         item_id_ff     <= in_item_id;
         new_value_ff   <= in_new_value;
         prior_value_ff <= in_prior_value;
         sq_new_ff      <= $unsigned(sq_new_in);
         sq_prior_ff    <= $unsigned(sq_prior_in);
      end
   end

   assign valid       = valid_ff;
   assign func        = func_ff;
   assign is_update   = is_update_ff;
   assign item_id     = item_id_ff;
   assign new_value   = new_value_ff;
   assign prior_value = prior_value_ff;
   assign sq_new      = sq_new_ff;
   assign sq_prior    = sq_prior_ff;

endmodule

[src/rstat_accum.sv]
// Count, sum and sum-of-squares registers; decodes each item into a step code.
// Depends on rstat_pkg.
module rstat_accum #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 func,
   input  logic                                 is_update,
   input  logic signed [VALUE_WIDTH-1:0]        new_value,
   input  logic signed [VALUE_WIDTH-1:0]        prior_value,
   input  logic [2*VALUE_WIDTH-1:0]             sq_new,
   input  logic [2*VALUE_WIDTH-1:0]             sq_prior,
   output rstat_pkg::step_ctl_type              ctl,
   output logic [rstat_pkg::COUNT_WIDTH-1:0]    point_count,
   output logic [rstat_pkg::SUM_WIDTH-1:0]      total,
   output logic [rstat_pkg::SQ_WIDTH-1:0]       total_squares,
   output logic                                 totals_valid
);

   localparam int CW = rstat_pkg::COUNT_WIDTH;
   localparam int SW = rstat_pkg::SUM_WIDTH;
   localparam int QW = rstat_pkg::SQ_WIDTH;

   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0] sq_ff, sq_in;
   logic          ok_ff, ok_in;
   logic [SW-1:0] v_ext, pv_ext;
   logic [QW-1:0] sqv_ext, sqpv_ext;
   logic          count_full;
   rstat_pkg::step_ctl_type ctl_c;

   assign v_ext      = {{(SW-VALUE_WIDTH){new_value[VALUE_WIDTH-1]}}, new_value};
   assign pv_ext     = {{(SW-VALUE_WIDTH){prior_value[VALUE_WIDTH-1]}}, prior_value};
   assign sqv_ext    = {{(QW-2*VALUE_WIDTH){1'b0}}, sq_new};
   assign sqpv_ext   = {{(QW-2*VALUE_WIDTH){1'b0}}, sq_prior};
   assign count_full = (count_ff == {CW{1'b1}});

   always_comb begin
      ctl_c.two = (!is_update && count_ff == CW'(1)) || (is_update && count_ff == CW'(2));
      if (func == rstat_pkg::FUNC_INVAL) begin
         ctl_c.op = rstat_pkg::OP_INVAL;
      end else if (count_ff == '0 || (is_update && count_ff == CW'(1))) begin
         ctl_c.op = rstat_pkg::OP_SOLE;
      end else if (!is_update) begin
         ctl_c.op = rstat_pkg::OP_ADD;
      end else begin
         ctl_c.op = rstat_pkg::OP_UPDATE;
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      ok_in    = ok_ff;
      case (ctl_c.op)
         rstat_pkg::OP_INVAL: begin
            if (!is_update && !count_full) begin
               count_in = count_ff + CW'(1);
            end
            ok_in  = 1'b0;
            sum_in = '0;
            sq_in  = '0;
         end
         rstat_pkg::OP_SOLE: begin
            count_in = CW'(1);
            ok_in    = 1'b1;
            sum_in   = v_ext;
            sq_in    = sqv_ext;
         end
         rstat_pkg::OP_ADD: begin
            if (!count_full) begin
               count_in = count_ff + CW'(1);
            end
            if (ok_ff) begin
               sum_in = sum_ff + v_ext;
               sq_in  = sq_ff + sqv_ext;
            end
         end
         rstat_pkg::OP_UPDATE: begin
            if (ok_ff) begin
               sum_in = sum_ff + v_ext - pv_ext;
               sq_in  = sq_ff + sqv_ext - sqpv_ext;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         ok_ff    <= 1'b1;
      end else if (advance) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         ok_ff    <= ok_in;
      end
   end

   assign ctl           = ctl_c;
   assign point_count   = count_ff;
   assign total         = sum_ff;
   assign total_squares = sq_ff;
   assign totals_valid  = ok_ff;

endmodule

[src/rstat_extreme.sv]
// First and second extreme with owner ids, for either direction.
// Depends on rstat_pkg; is_max selects maximum (1) or minimum (0).
module rstat_extreme #(
   parameter int VALUE_WIDTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          is_max,
   input  rstat_pkg::step_ctl_type       ctl,
   input  logic [ID_WIDTH-1:0]           item_id,
   input  logic signed [VALUE_WIDTH-1:0] new_value,
   output logic signed [VALUE_WIDTH-1:0] best_value,
   output logic [ID_WIDTH-1:0]           best_owner,
   output logic                          best_known
);

   logic signed [VALUE_WIDTH-1:0] v1_ff, v1_in, v2_ff, v2_in;
   logic [ID_WIDTH-1:0]           i1_ff, i1_in, i2_ff, i2_in;
   logic                          o1_ff, o1_in, o2_ff, o2_in;
   logic                          beats1, beats2, ge1, ge2;

   function automatic logic better(input logic dir,
                                   input logic signed [VALUE_WIDTH-1:0] a,
                                   input logic signed [VALUE_WIDTH-1:0] b);
      better = dir ? (a > b) : (a < b);
   endfunction

   function automatic logic not_worse(input logic dir,
                                      input logic signed [VALUE_WIDTH-1:0] a,
                                      input logic signed [VALUE_WIDTH-1:0] b);
      not_worse = dir ? (a >= b) : (a <= b);
   endfunction

   // lower id wins a tie
   assign beats1 = better(is_max, new_value, v1_ff) || (new_value == v1_ff && item_id < i1_ff);
   assign beats2 = better(is_max, new_value, v2_ff) || (new_value == v2_ff && item_id < i2_ff);
   assign ge1    = not_worse(is_max, new_value, v1_ff);
   assign ge2    = not_worse(is_max, new_value, v2_ff);

   always_comb begin
      v1_in = v1_ff;
      i1_in = i1_ff;
      o1_in = o1_ff;
      v2_in = v2_ff;
      i2_in = i2_ff;
      o2_in = o2_ff;
      case (ctl.op)
         rstat_pkg::OP_SOLE: begin
            v1_in = new_value;
            i1_in = item_id;
            o1_in = 1'b1;
            o2_in = 1'b0;
         end
         rstat_pkg::OP_INVAL: begin
            if (o1_ff) begin
               if (item_id == i1_ff || beats1) begin
                  o1_in = 1'b0;
               end else if (o2_ff && (item_id == i2_ff || beats2)) begin
                  o2_in = 1'b0;
               end
            end
         end
         rstat_pkg::OP_ADD: begin
            if (o1_ff) begin
               if (beats1) begin
                  v2_in = v1_ff;
                  i2_in = i1_ff;
                  o2_in = 1'b1;
                  v1_in = new_value;
                  i1_in = item_id;
               end else if (ctl.two || (o2_ff && beats2)) begin
                  v2_in = new_value;
                  i2_in = item_id;
                  o2_in = 1'b1;
               end
            end
         end
         rstat_pkg::OP_UPDATE: begin
            if (o1_ff) begin
               if (item_id == i1_ff) begin
                  // owner moved: keep if ahead, else promote runner-up, if any
                  if (ge1 || (o2_ff && beats2)) begin
                     v1_in = new_value;
                  end else if (o2_ff) begin
                     v1_in = v2_ff;
                     i1_in = i2_ff;
                     o2_in = 1'b0;
                  end else begin
                     o1_in = 1'b0;
                  end
               end else if (beats1) begin
                  v2_in = v1_ff;
                  i2_in = i1_ff;
                  o2_in = 1'b1;
                  v1_in = new_value;
                  i1_in = item_id;
               end else if (o2_ff && item_id == i2_ff) begin
                  if (ge2 || ctl.two) begin
                     v2_in = new_value;
                  end else begin
                     o2_in = 1'b0;
                  end
               end else if (ctl.two || (o2_ff && beats2)) begin
                  v2_in = new_value;
                  i2_in = item_id;
                  o2_in = 1'b1;
               end
            end
         end
         default: begin
            o1_in = o1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         i1_ff <= '0;
         o1_ff <= 1'b0;
         v2_ff <= '0;
         i2_ff <= '0;
         o2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         i1_ff <= i1_in;
         o1_ff <= o1_in;
         v2_ff <= v2_in;
         i2_ff <= i2_in;
         o2_ff <= o2_in;
      end
   end

   assign best_value = o1_ff ? v1_ff : '0;
   assign best_owner = o1_ff ? i1_ff : '0;
   assign best_known = o1_ff;

endmodule

[src/running_stats_top_two_min_max.sv]
// Top level of the running statistics block with top-two maxima and minima.
// Depends on rstat_pkg, rstat_square_stage, rstat_accum, rstat_extreme and the defines header.
//
//   channel | direction | tdata                                  | tuser
//   req     | in        | item_id, new_value, prior_value        | func, is_update
//   rsp     | out       | count, sums, valid, max and min fields | -
//
// One item per cycle sustained while rsp is not stalled; an item's result shows on rsp after it
// passes the input register with the squaring multipliers, then the state registers.
// The state registers are the result register: they load only when the result slot is
// empty or being taken, so a stalled rsp holds the state and back-pressures req.
// Reset is synchronous and returns all statistics to their empty state at once.
`include "running_stats_top_two_min_max_defines.svh"

module running_stats_top_two_min_max #(
   parameter int VALUE_WIDTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // item_id, new_value, prior_value, zero pad to whole bytes
   input  logic [((ID_WIDTH+2*VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // func, is_update
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // point_count, total, total_squares, totals_valid, max_value, max_owner, max_known,
   // min_value, min_owner, min_known, zero pad to whole bytes
   output logic [((rstat_pkg::COUNT_WIDTH+rstat_pkg::SUM_WIDTH+rstat_pkg::SQ_WIDTH+1
                   +2*(VALUE_WIDTH+ID_WIDTH+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int REQ_ID_LO  = 0;
   localparam int REQ_NEW_LO = ID_WIDTH;
   localparam int REQ_PRI_LO = ID_WIDTH + VALUE_WIDTH;
   localparam int RSP_W      = ((rstat_pkg::COUNT_WIDTH + rstat_pkg::SUM_WIDTH
                                 + rstat_pkg::SQ_WIDTH + 1
                                 + 2*(VALUE_WIDTH+ID_WIDTH+1) + 7)/8)*8;

   logic                          s1_valid, s1_func, s1_is_update, take;
   logic [ID_WIDTH-1:0]           s1_item_id;
   logic signed [VALUE_WIDTH-1:0] s1_new_value, s1_prior_value;
   logic [2*VALUE_WIDTH-1:0]      s1_sq_new, s1_sq_prior;
   logic                          rsp_valid_ff, rsp_valid_in;
   rstat_pkg::step_ctl_type       ctl;
   logic [rstat_pkg::COUNT_WIDTH-1:0] point_count;
   logic [rstat_pkg::SUM_WIDTH-1:0]   total;
   logic [rstat_pkg::SQ_WIDTH-1:0]    total_squares;
   logic                              totals_valid;
   logic signed [VALUE_WIDTH-1:0]     max_value, min_value;
   logic [ID_WIDTH-1:0]               max_owner, min_owner;
   logic                              max_known, min_known;

   // advance the input register into the state when the result slot frees up
   assign take = s1_valid && (!rsp_valid_ff || rsp_tready);

   rstat_square_stage #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_stage (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_func       (req_tuser[0]),
      .in_is_update  (req_tuser[1]),
      .in_item_id    (req_tdata[REQ_ID_LO +: ID_WIDTH]),
      .in_new_value  (req_tdata[REQ_NEW_LO +: VALUE_WIDTH]),
      .in_prior_value(req_tdata[REQ_PRI_LO +: VALUE_WIDTH]),
      .take          (take),
      .valid         (s1_valid),
      .func          (s1_func),
      .is_update     (s1_is_update),
      .item_id       (s1_item_id),
      .new_value     (s1_new_value),
      .prior_value   (s1_prior_value),
      .sq_new        (s1_sq_new),
      .sq_prior      (s1_sq_prior)
   );

   rstat_accum #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (take),
      .func         (s1_func),
      .is_update    (s1_is_update),
      .new_value    (s1_new_value),
      .prior_value  (s1_prior_value),
      .sq_new       (s1_sq_new),
      .sq_prior     (s1_sq_prior),
      .ctl          (ctl),
      .point_count  (point_count),
      .total        (total),
      .total_squares(total_squares),
      .totals_valid (totals_valid)
   );

   rstat_extreme #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_max (
      .clock     (clock),
      .reset     (reset),
      .advance   (take),
      .is_max    (1'b1),
      .ctl       (ctl),
      .item_id   (s1_item_id),
      .new_value (s1_new_value),
      .best_value(max_value),
      .best_owner(max_owner),
      .best_known(max_known)
   );

   rstat_extreme #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_min (
      .clock     (clock),
      .reset     (reset),
      .advance   (take),
      .is_max    (1'b0),
      .ctl       (ctl),
      .item_id   (s1_item_id),
      .new_value (s1_new_value),
      .best_value(min_value),
      .best_owner(min_owner),
      .best_known(min_known)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({min_known, min_owner, min_value,
                               max_known, max_owner, max_value,
                               totals_valid, total_squares, total, point_count});

   `RSTAT_ASSERT_NEXT(a_hold_pending, clock, reset, s1_valid && !take, s1_valid,
                      "pending item dropped from input register")
   `RSTAT_ASSERT_NEXT(a_take_shows, clock, reset, take, rsp_valid_ff,
                      "applied item produced no result")
   `RSTAT_ASSERT_NOW(a_inval_zero, clock, reset, !totals_valid,
                     total == '0 && total_squares == '0,
                     "invalid sums not cleared")

endmodule
